// ===== hdl/acked_packet_resend_scheduler_assert.svh =====
// Assertion macros for the resend scheduler RTL.
`ifndef ACKED_PACKET_RESEND_SCHEDULER_ASSERT_SVH
`define ACKED_PACKET_RESEND_SCHEDULER_ASSERT_SVH

`ifndef SYNTHESIS

`define APRS_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`define APRS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define APRS_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)

`define APRS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== hdl/aprs_pkg.sv =====
// Package: types, constants and codes of the resend scheduler.
package aprs_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam logic [7:0] RESEND_PERIOD_RST = 8'd3;
   localparam logic [3:0] MAX_ROUNDS_RST    = 4'd3;

   typedef enum logic [1:0] {
      FUNC_ADD   = 2'd0,
      FUNC_ACK   = 2'd1,
      FUNC_START = 2'd2,
      FUNC_TICK  = 2'd3
   } func_type;

   typedef enum logic {
      CSR_RESEND_PERIOD = 1'b0,
      CSR_MAX_ROUNDS    = 1'b1
   } csr_index_type;

   typedef struct packed {
      func_type    func;
      logic [31:0] cmd_tag;
      logic [15:0] group_tag;
      logic [31:0] payload_ref;
      logic [15:0] payload_len;
   } req_type;

   typedef struct packed {
      logic        send_now;
      logic [31:0] send_tag;
      logic [31:0] send_ref;
      logic [15:0] send_len;
      logic        all_acked;
      logic        add_dropped;
   } rsp_type;

   typedef struct packed {
      logic [31:0] tag;
      logic [31:0] pref;
      logic [15:0] len;
      logic        acked;
   } entry_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      entry_type         wdata;
      logic              re;
      logic [ADDR_W-1:0] raddr;
   } ram_req_type;

   typedef struct packed {
      logic [7:0] resend_period;
      logic [3:0] max_rounds;
   } cfg_type;

endpackage

// ===== hdl/aprs_entry_ram.sv =====
// Entry table: one write port, one registered read port.
module aprs_entry_ram
   import aprs_pkg::*;
(
   input  logic        clock,
   input  ram_req_type ram_req,
   output entry_type   ram_rdata
);

   entry_type mem [TABLE_DEPTH];
   entry_type rdata_ff;

   always_ff @(posedge clock) begin
      if (ram_req.we) begin
         mem[ram_req.waddr] <= ram_req.wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_req.re) begin
         rdata_ff <= mem[ram_req.raddr];
      end
   end

   assign ram_rdata = rdata_ff;

endmodule

// ===== hdl/aprs_ctrl.sv =====
// Sequencer: command decode, ack search, skip walk and send bookkeeping.
module aprs_ctrl
   import aprs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   input  cfg_type     cfg,
   output ram_req_type ram_req,
   input  entry_type   ram_rdata,
   output logic        rsp_valid,
   output rsp_type     rsp_data
);

`include "acked_packet_resend_scheduler_assert.svh"

   typedef enum logic [4:0] {
      ST_IDLE     = 5'b00001,
      ST_ACK_RD   = 5'b00010,
      ST_ACK_CHK  = 5'b00100,
      ST_SEND_RD  = 5'b01000,
      ST_SEND_CHK = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  cursor_ff, cursor_in;
   logic [CNT_W-1:0]  unacked_ff, unacked_in;
   logic [3:0]        round_ff, round_in;
   logic [15:0]       group_ff, group_in;
   logic              started_ff, started_in;
   logic [7:0]        tick_ff, tick_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [31:0]       tag_ff, tag_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              done;
   logic              snd;
   logic              dropped;
   logic [CNT_W-1:0]  cnt_v;
   logic [CNT_W-1:0]  unack_v;
   logic [3:0]        round_v;
   entry_type         ent_v;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      cursor_in    = cursor_ff;
      unacked_in   = unacked_ff;
      round_in     = round_ff;
      group_in     = group_ff;
      started_in   = started_ff;
      tick_in      = tick_ff;
      idx_in       = idx_ff;
      tag_in       = tag_ff;
      ram_req      = '0;
      done         = 1'b0;
      snd          = 1'b0;
      dropped      = 1'b0;
      cnt_v        = count_ff;
      unack_v      = unacked_ff;
      round_v      = round_ff;
      ent_v        = ram_rdata;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (req_data.func)
                  FUNC_ADD: begin
                     if (req_data.group_tag != group_ff) begin
                        group_in  = req_data.group_tag;
                        cnt_v     = '0;
                        unack_v   = '0;
                        cursor_in = '0;
                     end
                     count_in   = cnt_v;
                     unacked_in = unack_v;
                     if (cnt_v >= CNT_W'(TABLE_DEPTH)) begin
                        dropped = 1'b1;
                     end else begin
                        ram_req.we          = 1'b1;
                        ram_req.waddr       = cnt_v[ADDR_W-1:0];
                        ram_req.wdata.tag   = req_data.cmd_tag;
                        ram_req.wdata.pref  = req_data.payload_ref;
                        ram_req.wdata.len   = req_data.payload_len;
                        ram_req.wdata.acked = 1'b0;
                        count_in            = cnt_v + CNT_W'(1);
                        unacked_in          = unack_v + CNT_W'(1);
                     end
                     done = 1'b1;
                  end
                  FUNC_ACK: begin
                     if (started_ff && count_ff != '0) begin
                        tag_in   = req_data.cmd_tag;
                        idx_in   = '0;
                        state_in = ST_ACK_RD;
                     end else begin
                        done = 1'b1;
                     end
                  end
                  FUNC_START: begin
                     started_in = 1'b1;
                     if (count_ff != '0) begin
                        round_in  = '0;
                        cursor_in = '0;
                        state_in  = ST_SEND_RD;
                     end else begin
                        done = 1'b1;
                     end
                  end
                  FUNC_TICK: begin
                     if (started_ff) begin
                        if ({1'b0, tick_ff} + 9'd1 >= {1'b0, cfg.resend_period}) begin
                           tick_in = '0;
                           if (count_ff != '0) begin
                              state_in = ST_SEND_RD;
                           end else begin
                              done = 1'b1;
                           end
                        end else begin
                           tick_in = tick_ff + 8'd1;
                           done    = 1'b1;
                        end
                     end else begin
                        done = 1'b1;
                     end
                  end
                  default: done = 1'b1;
               endcase
            end
         end
         ST_ACK_RD: begin
            ram_req.re    = 1'b1;
            ram_req.raddr = idx_ff;
            state_in      = ST_ACK_CHK;
         end
         ST_ACK_CHK: begin
            if (ram_rdata.tag == tag_ff) begin
               if (!ram_rdata.acked) begin
                  ram_req.we          = 1'b1;
                  ram_req.waddr       = idx_ff;
                  ram_req.wdata       = ram_rdata;
                  ram_req.wdata.acked = 1'b1;
                  unacked_in          = unacked_ff - CNT_W'(1);
               end
               state_in = ST_SEND_RD;
            end else if (CNT_W'(idx_ff) + CNT_W'(1) >= count_ff) begin
               state_in = ST_SEND_RD;
            end else begin
               idx_in   = idx_ff + ADDR_W'(1);
               state_in = ST_ACK_RD;
            end
         end
         ST_SEND_RD: begin
            if (cursor_ff >= count_ff) begin
               done = 1'b1;
            end else begin
               ram_req.re    = 1'b1;
               ram_req.raddr = cursor_ff[ADDR_W-1:0];
               state_in      = ST_SEND_CHK;
            end
         end
         ST_SEND_CHK: begin
            if (ram_rdata.acked) begin
               cursor_in = cursor_ff + CNT_W'(1);
               state_in  = ST_SEND_RD;
            end else begin
               snd     = 1'b1;
               tick_in = '0;
               if (cursor_ff + CNT_W'(1) == count_ff) begin
                  round_v   = round_ff + 4'd1;
                  cursor_in = '0;
                  if (round_v >= cfg.max_rounds) begin
                     count_in   = '0;
                     unacked_in = '0;
                     round_in   = '0;
                  end else begin
                     round_in = round_v;
                  end
               end else begin
                  cursor_in = cursor_ff + CNT_W'(1);
               end
               done = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (done) begin
         state_in = ST_IDLE;
      end
      rsp_valid_in        = done;
      rsp_in              = rsp_ff;
      if (done) begin
         rsp_in.send_now    = snd;
         rsp_in.send_tag    = snd ? ent_v.tag : '0;
         rsp_in.send_ref    = snd ? ent_v.pref : '0;
         rsp_in.send_len    = snd ? ent_v.len : '0;
         rsp_in.all_acked   = (unacked_in == '0);
         rsp_in.add_dropped = dropped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cursor_ff    <= '0;
         unacked_ff   <= '0;
         round_ff     <= '0;
         group_ff     <= '0;
         started_ff   <= 1'b0;
         tick_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cursor_ff    <= cursor_in;
         unacked_ff   <= unacked_in;
         round_ff     <= round_in;
         group_ff     <= group_in;
         started_ff   <= started_in;
         tick_ff      <= tick_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      tag_ff <= tag_in;
      rsp_ff <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `APRS_ASSERT_SAME(a_unacked_le_count, clock, reset, 1'b1, unacked_ff <= count_ff, "unacked count exceeds entry count")
   `APRS_ASSERT_SAME(a_count_le_depth, clock, reset, 1'b1, count_ff <= CNT_W'(TABLE_DEPTH), "entry count exceeds table depth")
   `APRS_ASSERT_SAME(a_rsp_when_idle, clock, reset, rsp_valid_ff, state_ff == ST_IDLE, "result while sequencer busy")
   `APRS_ASSERT_NEXT(a_accept_progress, clock, reset, start && !busy, rsp_valid_ff || busy, "accepted command made no progress")
   `APRS_ASSERT_SAME(a_send_has_entries, clock, reset, state_ff == ST_SEND_CHK, cursor_ff < count_ff, "send check past table end")

endmodule

// ===== hdl/acked_packet_resend_scheduler.sv =====
// Top level of the acked packet resend scheduler.
//
//  port group | direction | transfer
//  req_*      | in        | start high while busy low
//  rsp_*      | out       | rsp_valid high for one cycle, always taken
//  csr_*      | in        | csr_valid and csr_ready high
//
// Add, ignored ack/start and non-firing tick: result in the cycle after the transfer.
// Ack, start and firing tick: each entry is read through the entry RAM's single read port,
// a read state then a check state per entry (ack tag search, then skip over acked entries).
// Reset is synchronous and clears control state; the entry RAM is not cleared.
// busy is high while a command is in progress; results cannot be stalled.
// csr_ready is always high; the user must write registers only while idle; the block does not enforce this.
module acked_packet_resend_scheduler
   import aprs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  req_type       req_data,
   output logic          rsp_valid,
   output rsp_type       rsp_data,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  csr_index_type csr_index,
   input  logic [7:0]    csr_data
);

   cfg_type     cfg_ff;
   ram_req_type ram_req;
   entry_type   ram_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.resend_period <= RESEND_PERIOD_RST;
         cfg_ff.max_rounds    <= MAX_ROUNDS_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_RESEND_PERIOD: cfg_ff.resend_period <= csr_data;
            CSR_MAX_ROUNDS:    cfg_ff.max_rounds    <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   aprs_entry_ram u_entry_ram (
      .clock     (clock),
      .ram_req   (ram_req),
      .ram_rdata (ram_rdata)
   );

   aprs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .ram_req   (ram_req),
      .ram_rdata (ram_rdata),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the acked packet resend scheduler: directed and random commands.
`timescale 1ns / 1ps

module tb;
   import aprs_pkg::*;

   localparam int QUIET_LIMIT = 3000;
   localparam int PHASES      = 6;
   localparam int PHASE_ITEMS = 115;

   class resend_tracker;
      rsp_type     pending_rsp[$];
      logic [31:0] tag_mem[TABLE_DEPTH];
      logic [31:0] ref_mem[TABLE_DEPTH];
      logic [15:0] len_mem[TABLE_DEPTH];
      bit          acked_mem[TABLE_DEPTH];
      int          fill = 0;
      int          cursor = 0;
      logic [3:0]  passes = '0;
      logic [15:0] group = '0;
      bit          running = 0;
      logic [7:0]  ticks = '0;
      logic [7:0]  period = RESEND_PERIOD_RST;
      logic [3:0]  rounds_max = MAX_ROUNDS_RST;
      int          errors = 0;
      int          sends = 0;
      int          drops = 0;
      int          checked = 0;

      function void set_reg(csr_index_type idx, logic [7:0] d);
         if (idx == CSR_RESEND_PERIOD) period = d;
         else rounds_max = d[3:0];
      endfunction

      // next unacked entry from the cursor; a finished pass may clear the table
      function void transmit_next(inout rsp_type r);
         if (fill == 0) return;
         while (cursor < fill && acked_mem[cursor]) cursor++;
         if (cursor >= fill) return;
         r.send_now = 1'b1;
         r.send_tag = tag_mem[cursor];
         r.send_ref = ref_mem[cursor];
         r.send_len = len_mem[cursor];
         ticks = '0;
         sends++;
         cursor++;
         if (cursor == fill) begin
            passes = passes + 4'd1;
            if (passes >= rounds_max) begin
               fill = 0;
               passes = '0;
            end
            cursor = 0;
         end
      endfunction

      function void note_request(req_type q);
         rsp_type r;
         int i;
         r = '0;
         case (q.func)
            FUNC_ADD: begin
               if (q.group_tag != group) begin
                  group = q.group_tag;
                  fill = 0;
                  cursor = 0;
               end
               if (fill >= TABLE_DEPTH) begin
                  r.add_dropped = 1'b1;
                  drops++;
               end else begin
                  tag_mem[fill] = q.cmd_tag;
                  ref_mem[fill] = q.payload_ref;
                  len_mem[fill] = q.payload_len;
                  acked_mem[fill] = 0;
                  fill++;
               end
            end
            FUNC_ACK: begin
               if (running && fill != 0) begin
                  for (i = 0; i < fill; i++) begin
                     if (tag_mem[i] == q.cmd_tag) begin
                        acked_mem[i] = 1;
                        break;
                     end
                  end
                  transmit_next(r);
               end
            end
            FUNC_START: begin
               running = 1;
               if (fill != 0) begin
                  passes = '0;
                  cursor = 0;
                  transmit_next(r);
               end
            end
            default: begin
               if (running) begin
                  if (int'(ticks) + 1 >= int'(period)) begin
                     ticks = '0;
                     transmit_next(r);
                  end else begin
                     ticks = ticks + 8'd1;
                  end
               end
            end
         endcase
         r.all_acked = 1'b1;
         for (i = 0; i < fill; i++) begin
            if (!acked_mem[i]) r.all_acked = 1'b0;
         end
         pending_rsp = {pending_rsp, r};
      endfunction

      function void compare(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s expected %h actual %h", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending_rsp.size() == 0) begin
            $error("result with no command outstanding: %h", got);
            errors++;
            return;
         end
         want = pending_rsp.pop_front();
         checked++;
         compare("send_now", 32'(want.send_now), 32'(got.send_now));
         compare("send_tag", want.send_tag, got.send_tag);
         compare("send_ref", want.send_ref, got.send_ref);
         compare("send_len", 32'(want.send_len), 32'(got.send_len));
         compare("all_acked", 32'(want.all_acked), 32'(got.all_acked));
         compare("add_dropped", 32'(want.add_dropped), 32'(got.add_dropped));
      endfunction
   endclass

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          start = 1'b0;
   logic          busy;
   req_type       req_data = '0;
   logic          rsp_valid;
   rsp_type       rsp_data;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = CSR_RESEND_PERIOD;
   logic [7:0]    csr_data = '0;

   resend_tracker sb = new;
   int            quiet_cycles = 0;
   int            items_sent = 0;
   int            idle_pct = 0;
   int            phase_period[PHASES] = '{1, 2, 255, 4, 0, 5};
   int            phase_rounds[PHASES] = '{1, 15, 2, 3, 0, 7};
   int            phase_idle[PHASES]   = '{0, 71, 0, 15, 71, 0};

   acked_packet_resend_scheduler i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (!reset && rsp_valid) sb.check_result(rsp_data);
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("TB_ERROR");
      $finish;
   end

   task automatic push_item(input req_type r);
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      sb.note_request(r);
      items_sent++;
      if ($urandom_range(1, 100) <= idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // hold off until every result is back and the block is idle
   task automatic settle();
      start <= 1'b0;
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      while (busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [7:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= d;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.set_reg(idx, d);
      @(posedge clock);
   endtask

   function automatic req_type rand_item(func_type f);
      req_type r;
      r.func        = f;
      r.cmd_tag     = $urandom;
      r.group_tag   = 16'($urandom);
      r.payload_ref = $urandom;
      r.payload_len = 16'($urandom);
      return r;
   endfunction

   task automatic cmd(input func_type f, input logic [31:0] tag, input logic [15:0] grp,
                      input logic [31:0] pref, input logic [15:0] len);
      req_type r;
      r.func        = f;
      r.cmd_tag     = tag;
      r.group_tag   = grp;
      r.payload_ref = pref;
      r.payload_len = len;
      push_item(r);
   endtask

   // fill a group, usually start it, then acks and ticks with some late adds
   task automatic run_session();
      logic [31:0] tags[$];
      logic [15:0] grp;
      req_type     r;
      int          n;
      int          m;
      int          k;
      int          pick;
      grp = ($urandom_range(0, 2) == 0) ? sb.group : 16'($urandom);
      if ($urandom_range(0, 15) == 0) grp = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hffff;
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 18) : $urandom_range(1, 4);
      for (k = 0; k < n; k++) begin
         r = rand_item(FUNC_ADD);
         r.group_tag = grp;
         if (tags.size() != 0 && $urandom_range(0, 7) == 0)
            r.cmd_tag = tags[$urandom_range(0, tags.size() - 1)];
         tags = {tags, r.cmd_tag};
         push_item(r);
      end
      if ($urandom_range(0, 9) != 0) push_item(rand_item(FUNC_START));
      m = $urandom_range(4, 24);
      for (k = 0; k < m; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            r = rand_item(FUNC_ACK);
            r.cmd_tag = tags[$urandom_range(0, tags.size() - 1)];
         end else if (pick < 55) begin
            r = rand_item(FUNC_ACK);
         end else if (pick < 88) begin
            r = rand_item(FUNC_TICK);
         end else if (pick < 95) begin
            r = rand_item(FUNC_ADD);
            r.group_tag = grp;
            tags = {tags, r.cmd_tag};
         end else begin
            r = rand_item(FUNC_START);
         end
         push_item(r);
      end
   endtask

   initial begin
      int p;
      int k;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // before start, then start on an empty table
      cmd(FUNC_ACK, 32'h0, 16'h0, 32'h0, 16'h0);
      cmd(FUNC_TICK, 32'hffff_ffff, 16'hffff, 32'hffff_ffff, 16'hffff);
      cmd(FUNC_START, 32'h0, 16'h0, 32'h0, 16'h0);
      cmd(FUNC_ADD, 32'hffff_ffff, 16'h0, 32'h0, 16'hffff);
      cmd(FUNC_ADD, 32'h0, 16'h0, 32'hffff_ffff, 16'h0);
      for (k = 2; k <= TABLE_DEPTH; k++) cmd(FUNC_ADD, $urandom, 16'h0, $urandom, 16'($urandom));
      // ack matching entry 0, then an ack with no match, then a timer expiry
      cmd(FUNC_ACK, 32'hffff_ffff, 16'h0, 32'h0, 16'h0);
      cmd(FUNC_ACK, 32'h0bad_f00d, 16'h0, 32'h0, 16'h0);
      repeat (3) cmd(FUNC_TICK, 32'h0, 16'h0, 32'h0, 16'h0);
      cmd(FUNC_ADD, 32'h1234_5678, 16'hffff, 32'h8765_4321, 16'h8000);
      settle();

      for (p = 0; p < PHASES; p++) begin
         write_reg(CSR_RESEND_PERIOD, 8'(phase_period[p]));
         write_reg(CSR_MAX_ROUNDS, 8'(phase_rounds[p]));
         idle_pct = phase_idle[p];
         k = items_sent + PHASE_ITEMS;
         while (items_sent < k) begin
            if ($urandom_range(0, 9) == 0) begin
               repeat ($urandom_range(1, 5))
                  push_item(rand_item(func_type'($urandom_range(0, 3))));
            end else begin
               run_session();
            end
            if ($urandom_range(0, 29) == 0) settle();
         end
         settle();
      end

      repeat (80) @(posedge clock);
      $display("Ran %0d commands over %0d register settings; %0d results checked.",
               items_sent, PHASES + 1, sb.checked);
      $display("Seen %0d packet sends and %0d adds refused on a full table.",
               sb.sends, sb.drops);
      if (sb.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
